FILE: design/isort_pkg.sv
// shared types and constants for the insertion sorter
package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_result;
    logic                      overflowed;
  } result_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      gt;
    logic signed [VALUE_W-1:0] data;
  } link_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      shift;
    logic signed [VALUE_W-1:0] ins_value;
  } ctrl_t;

  typedef enum logic {
    ST_FILL  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

endpackage

FILE: design/isort_cell.sv
// one compare-and-hold cell of the sorting chain
module isort_cell (
  input  logic                clk,
  input  logic                rst,
  input  isort_pkg::ctrl_t    ctrl,
  input  isort_pkg::link_t    left,
  input  isort_pkg::link_t    right,
  output isort_pkg::link_t    link
);

  logic                               valid;
  logic signed [isort_pkg::VALUE_W-1:0] data;
  logic                               gt;
  logic                               take;

  assign gt   = valid && (data > ctrl.ins_value);
  // take a value when displaced by a smaller one, or when first empty cell
  assign take = gt || (!valid && left.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (ctrl.ins && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right.data;
    end else if (ctrl.ins && take) begin
      data <= left.gt ? left.data : ctrl.ins_value;
    end
  end

  assign link.valid = valid;
  assign link.gt    = gt;
  assign link.data  = data;

endmodule

FILE: design/insertion_sorter.sv
// insertion sorter top level: chain of cells, fill and drain control
//
//   channel   signals                        payload
//   item      item_valid, item_ready, item   isort_pkg::item_t
//   result    result_valid, result_ready, result  isort_pkg::result_t
//
// filling: one item per cycle, inserted by all cells at once
// a last item starts a drain of n results, one per cycle unless stalled,
// shifting the chain toward cell 0; no items are taken while a drain is in progress
// items beyond MAX_ITEMS are dropped and flag overflow for the whole set
// reset clears the cell valid bits, fill state and overflow flag at once
// a stalled result holds cell 0 and the chain until the transfer
module insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  isort_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output isort_pkg::result_t result
);

  isort_pkg::state_t state;
  isort_pkg::state_t state_next;
  logic              overflow;
  logic              overflow_next;
  isort_pkg::ctrl_t  ctrl;
  isort_pkg::link_t  links [MAX_ITEMS];
  isort_pkg::link_t  left_edge;
  isort_pkg::link_t  right_edge;
  logic [MAX_ITEMS-1:0] vld;
  logic              full;
  logic              item_xfer;
  logic              result_xfer;

  assign left_edge  = '{valid: 1'b1, gt: 1'b0, data: '0};
  assign right_edge = '{valid: 1'b0, gt: 1'b0, data: '0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  ((i == 0) ? left_edge : links[(i == 0) ? 0 : i-1]),
      .right ((i == MAX_ITEMS-1) ? right_edge : links[(i == MAX_ITEMS-1) ? i : i+1]),
      .link  (links[i])
    );
    assign vld[i] = links[i].valid;
  end

  assign full        = vld[MAX_ITEMS-1];
  assign item_xfer   = item_valid && item_ready;
  assign result_xfer = result_valid && result_ready;

  // next state
  always_comb begin
    state_next    = state;
    overflow_next = overflow;
    case (state)
      isort_pkg::ST_FILL: begin
        if (item_xfer) begin
          if (full) begin
            overflow_next = 1'b1;
          end
          if (item.last_item) begin
            state_next = isort_pkg::ST_DRAIN;
          end
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (result_xfer && result.last_result) begin
          state_next    = isort_pkg::ST_FILL;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = isort_pkg::ST_FILL;
      end
    endcase
  end

  // outputs
  always_comb begin
    item_ready          = 1'b0;
    result_valid        = 1'b0;
    ctrl.ins            = 1'b0;
    ctrl.shift          = 1'b0;
    ctrl.ins_value      = item.value;
    case (state)
      isort_pkg::ST_FILL: begin
        item_ready = 1'b1;
        ctrl.ins   = item_valid && !full;
      end
      isort_pkg::ST_DRAIN: begin
        result_valid = vld[0];
        ctrl.shift   = result_ready && vld[0];
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  assign result.sorted_value = links[0].data;
  assign result.last_result  = !vld[1];
  assign result.overflowed   = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= isort_pkg::ST_FILL;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      overflow <= overflow_next;
    end
  end

`ifndef SYNTHESIS
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == isort_pkg::ST_DRAIN |-> vld[0])
    else $error("drain with empty chain");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld & (vld + 1'b1)) == '0)
    else $error("cell valid bits not a prefix");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    result_xfer && result.last_result |=>
      state == isort_pkg::ST_FILL && vld == '0 && !overflow)
    else $error("store not empty after run end");

  a_drop_flags: assert property (@(posedge clk) disable iff (rst)
    item_xfer && full |=> overflow)
    else $error("dropped item without overflow");
`endif

endmodule

FILE: tb/tb_insertion_sorter.sv
// testbench for the insertion sorter: predicts each sorted set and checks every result transfer
module tb_insertion_sorter;

  localparam int unsigned MAX_ITEMS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS_PER_PHASE = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  isort_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  isort_pkg::result_t result;

  isort_pkg::item_t items_pending[$];
  isort_pkg::result_t sorted_expected[$];

  logic signed [isort_pkg::VALUE_W-1:0] model_store [MAX_ITEMS];
  int model_count = 0;
  logic model_overflow = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  insertion_sorter #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic insert_and_sort(input isort_pkg::item_t it);
    int pos;
    isort_pkg::result_t r;
    if (model_count >= MAX_ITEMS) begin
      model_overflow = 1'b1;
    end else begin
      pos = model_count;
      while (pos > 0 && model_store[pos-1] > it.value) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = it.value;
      model_count++;
    end
    if (it.last_item) begin
      for (int k = 0; k < model_count; k++) begin
        r.sorted_value = model_store[k];
        r.last_result = (k == model_count - 1);
        r.overflowed = model_overflow;
        sorted_expected = {sorted_expected, r};
      end
      model_count = 0;
      model_overflow = 1'b0;
    end
  endtask

  function automatic logic signed [isort_pkg::VALUE_W-1:0] pick_value();
    logic signed [isort_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: v = {1'b1, {(isort_pkg::VALUE_W-1){1'b0}}};
      1: v = {1'b0, {(isort_pkg::VALUE_W-1){1'b1}}};
      2, 3, 4: v = $signed($urandom_range(15)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_set(input int size);
    isort_pkg::item_t it;
    for (int i = 0; i < size; i++) begin
      it.value = pick_value();
      it.last_item = (i == size - 1);
      items_pending = {items_pending, it};
    end
  endtask

  task automatic queue_item(input int v, input logic is_last);
    isort_pkg::item_t it;
    it.value = v;
    it.last_item = is_last;
    items_pending = {items_pending, it};
  endtask

  // sender: a held item stays until its transfer
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (items_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= items_pending.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        insert_and_sort(item);
      end
      if (result_valid && result_ready) begin
        if (sorted_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: value %0d last %0b overflow %0b",
                     result.sorted_value, result.last_result, result.overflowed);
          end
        end else begin
          if (result !== sorted_expected[0]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                       sorted_expected[0].sorted_value, sorted_expected[0].last_result,
                       sorted_expected[0].overflowed, result.sorted_value,
                       result.last_result, result.overflowed);
            end
          end
          void'(sorted_expected.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("insertion_sorter test failed");
      $finish;
    end
  end

  initial begin
    int queued;
    int size;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single element set at the top of the range
    queue_item(32'h7fffffff, 1'b1);
    // extremes, zero, minus one and repeated values
    queue_item(32'h7fffffff, 1'b0);
    queue_item(32'h80000000, 1'b0);
    queue_item(0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(32'h80000000, 1'b0);
    queue_item(0, 1'b1);
    // full store, then a last item that is dropped
    for (int i = 0; i < MAX_ITEMS; i++) begin
      queue_item(MAX_ITEMS - 2 * i, 1'b0);
    end
    queue_item(32'h80000000, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      while (items_pending.size() != 0 || item_valid || sorted_expected.size() != 0) begin
        @(negedge clk);
      end
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      queued = 0;
      while (queued < RANDOM_ITEMS_PER_PHASE) begin
        if ($urandom_range(9) < 8) begin
          size = $urandom_range(MAX_ITEMS, 1);
        end else begin
          size = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS + 1);
        end
        queue_set(size);
        queued += size;
      end
    end

    while (items_pending.size() != 0 || item_valid || sorted_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && sorted_expected.size() == 0) begin
      $display("insertion_sorter test passed");
    end else begin
      $display("insertion_sorter test failed");
    end
    $finish;
  end

endmodule
